### sv/rle_dec_pkg.sv
// Shared types and constants for the run-length packet decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps

package rle_dec_pkg;

  // Field widths fixed by the stream format
  localparam int WORD_W     = 16;
  localparam int RUN_W      = 8;
  localparam int TARGET_W   = 20;
  localparam int CONSUMED_W = 20;
  localparam int TDATA_W    = 48;  // value + run_length + consumed_words, byte padded

  // Default width of the image counters
  localparam int TOTAL_WIDTH_DEF = 20;

  // Header decode: bit 7 marks a repeat packet, count is header minus the bias
  localparam int            REPEAT_FLAG_BIT = 7;
  localparam logic [RUN_W-1:0] REPEAT_BIAS  = 8'h7F;

  // Packet phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_t;

  // Registered input request handed to the decode stage
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] word;
  } in_req_t;

endpackage

### sv/rle_dec_in_stage.sv
// Input register of the decoder: captures one raw word per request.
// Depends on rle_dec_pkg.
`timescale 1ns / 1ps

module rle_dec_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rle_dec_pkg::WORD_W-1:0] in_tdata,
  input  logic                          take,      // decode stage consumes the held word
  output rle_dec_pkg::in_req_t          req
);
  import rle_dec_pkg::*;

  logic              valid_r, valid_nxt;
  logic [WORD_W-1:0] word_r;

  // Free when empty or when the held word leaves this cycle
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      word_r <= in_tdata;
    end
  end

  assign req.valid = valid_r;
  assign req.word  = word_r;

endmodule

### sv/rle_dec_core.sv
// Decode stage: packet state, image counters, target register and result register.
// Depends on rle_dec_pkg.
`timescale 1ns / 1ps

module rle_dec_core #(
  parameter int TOTAL_WIDTH = rle_dec_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rle_dec_pkg::in_req_t             req,
  output logic                             take,
  input  logic                             cfg_valid,
  input  logic [rle_dec_pkg::TARGET_W-1:0] cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rle_dec_pkg::WORD_W-1:0]   out_value,
  output logic [rle_dec_pkg::RUN_W-1:0]    out_run,
  output logic                             out_last,
  output logic [rle_dec_pkg::CONSUMED_W-1:0] out_consumed
);
  import rle_dec_pkg::*;

  localparam int SUM_W = TOTAL_WIDTH + 1;
  localparam int CMP_W = (TOTAL_WIDTH > TARGET_W) ? TOTAL_WIDTH : TARGET_W;
  localparam int EXT_W = (TOTAL_WIDTH > CONSUMED_W) ? TOTAL_WIDTH : CONSUMED_W;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

  // State
  phase_t                 phase_r, phase_nxt;
  logic [RUN_W-1:0]       pending_r, pending_nxt;
  logic [TOTAL_WIDTH-1:0] produced_r, produced_nxt;
  logic [TOTAL_WIDTH-1:0] consumed_r, consumed_nxt;
  logic [TARGET_W-1:0]    target_r;

  // Result register
  logic                   out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]      value_r;
  logic [RUN_W-1:0]       run_r;
  logic                   last_r;
  logic [CONSUMED_W-1:0]  consumed_out_r;

  // Decode intermediates
  logic                   emit;
  logic                   pkt_end;
  logic [RUN_W-1:0]       run;
  logic [RUN_W-1:0]       hdr;
  logic [RUN_W-1:0]       pend_dec;
  logic [TOTAL_WIDTH-1:0] consumed_inc;
  logic [EXT_W-1:0]       consumed_ext;
  logic [SUM_W-1:0]       prod_sum;
  logic [TOTAL_WIDTH-1:0] prod_sat;
  logic                   is_last;

  // A held word moves on when the result register is free or being drained
  assign take = req.valid && (!out_valid_r || out_ready);

  assign hdr      = req.word[RUN_W-1:0];
  assign pend_dec = pending_r - RUN_W'(1);

  // Next phase and pending count
  always_comb begin
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    emit        = 1'b0;
    pkt_end     = 1'b0;
    run         = RUN_W'(1);
    case (phase_r)
      PH_REPEAT: begin
        emit        = 1'b1;
        pkt_end     = 1'b1;
        run         = pending_r;
        phase_nxt   = PH_HEADER;
        pending_nxt = '0;
      end
      PH_LITERAL: begin
        emit        = 1'b1;
        pkt_end     = (pend_dec == '0);
        pending_nxt = pend_dec;
        if (pend_dec == '0) begin
          phase_nxt = PH_HEADER;
        end
      end
      default: begin
        // Header (an unused code behaves the same)
        if (hdr[REPEAT_FLAG_BIT]) begin
          phase_nxt   = PH_REPEAT;
          pending_nxt = hdr - REPEAT_BIAS;
        end else begin
          phase_nxt   = PH_LITERAL;
          pending_nxt = hdr + RUN_W'(1);
        end
      end
    endcase
  end

  // Saturating image counters and end-of-image test
  always_comb begin
    consumed_inc = (consumed_r == TOTAL_MAX) ? TOTAL_MAX : consumed_r + TOTAL_WIDTH'(1);
    consumed_ext = EXT_W'(consumed_inc);
    prod_sum     = SUM_W'(produced_r) + SUM_W'(run);
    prod_sat     = prod_sum[TOTAL_WIDTH] ? TOTAL_MAX : prod_sum[TOTAL_WIDTH-1:0];
    is_last      = pkt_end &&
                   ((CMP_W'(prod_sat) >= CMP_W'(target_r)) || (prod_sat == TOTAL_MAX));
    produced_nxt = produced_r;
    consumed_nxt = consumed_inc;
    if (emit) begin
      produced_nxt = prod_sat;
    end
    if (is_last) begin
      produced_nxt = '0;
      consumed_nxt = '0;
    end
  end

  // Result valid: loaded on an emitting word, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pending_r   <= '0;
      produced_r  <= '0;
      consumed_r  <= '0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        phase_r    <= phase_nxt;
        pending_r  <= pending_nxt;
        produced_r <= produced_nxt;
        consumed_r <= consumed_nxt;
      end
      if (cfg_valid) begin
        target_r <= cfg_data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      value_r        <= req.word;
      run_r          <= run;
      last_r         <= is_last;
      consumed_out_r <= consumed_ext[CONSUMED_W-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = value_r;
  assign out_run      = run_r;
  assign out_last     = last_r;
  assign out_consumed = consumed_out_r;

endmodule

### sv/rle_packet_decoder.sv
// PackBits-style run-length decoder, 16-bit words, one run descriptor per result.
// Input register, then result register; throughput one word per cycle while out_tready is not held low.
// Headers produce no result; repeat packets give one result, literals one per word.
// Reset (rst_n low, synchronous) clears packet state, image counters and target.
// Depends on rle_dec_pkg, rle_dec_in_stage and rle_dec_core.
`timescale 1ns / 1ps

module rle_packet_decoder #(
  parameter int TOTAL_WIDTH = rle_dec_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: [15:0] raw_word
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rle_dec_pkg::WORD_W-1:0]    in_tdata,
  // tdata: [15:0] value, [23:16] run_length, [43:24] consumed_words, [47:44] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rle_dec_pkg::TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast,
  // target_words write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rle_dec_pkg::TARGET_W-1:0]  cfg_data
);
  import rle_dec_pkg::*;

  in_req_t               req;
  logic                  take;
  logic [WORD_W-1:0]     value;
  logic [RUN_W-1:0]      run_length;
  logic [CONSUMED_W-1:0] consumed_words;

  assign cfg_ready = 1'b1;

  rle_dec_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .req       (req)
  );

  rle_dec_core #(
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .take         (take),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_value    (value),
    .out_run      (run_length),
    .out_last     (out_tlast),
    .out_consumed (consumed_words)
  );

  // Pack the result fields, lowest first
  assign out_tdata = {{(TDATA_W - WORD_W - RUN_W - CONSUMED_W){1'b0}},
                      consumed_words, run_length, value};

endmodule
